@@ src/hmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hmt_pkg;

    // Fixed field widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int MASK_W  = 9;
    localparam int WIN_N   = 9;
    localparam int IDX_W   = 4;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 4'd1;
    localparam logic [IDX_W-1:0] REG_CARE   = 4'd2;
    localparam logic [IDX_W-1:0] REG_VALUE  = 4'd3;

    // Input opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

    // One result beat
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } result_t;

    // Control carried from the address stage to the data stage
    typedef struct packed {
        logic             is_pixel;
        logic             emit;
        logic             border;
        logic             last;
        logic             use_upper;
        logic             fwd;
        logic [PIX_W-1:0] px;
    } s1_t;

    // All cared-for window positions hold their required level
    function automatic logic win_match(input win_t win, input logic [MASK_W-1:0] care,
                                       input logic [MASK_W-1:0] value);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < WIN_N; k++)
        begin
            if (care[k] && (win[k] != (value[k] ? PIX_MAX : PIX_MIN)))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ src/hmt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, read-first, registered read data
module hmt_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output      logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/hmt_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Three-entry result queue between the data stage and the output port
module hmt_out_fifo
    import hmt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output      logic    valid,
    output      result_t head,
    output      logic [1:0] level
);

    localparam logic [1:0] LAST_SLOT = 2'd2;

    result_t    slot_reg [3];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign valid  = (count_reg != 2'd0);
    assign head   = slot_reg[rd_ptr_reg];
    assign level  = count_reg;
    assign do_pop = pop && valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/binary_hit_or_miss_3x3.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  opcode, pixel_in
// out       output     out_valid / out_stall pixel_out, frame_last
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat per cycle sustained in both directions while neither side stalls. Once a beat
// is accepted, the line stores are read and the beat is held in the data stage register;
// the window is then updated and the result written into the queue that drives out_valid.
// Reset clears counters, window and queue; line stores hold whatever they had.
// in_stall rises only when the three-entry result queue plus the result in flight
// would fill it, i.e. after the output has stalled.
module binary_hit_or_miss_3x3
    import hmt_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic             opcode,
    input  wire logic [PIX_W-1:0] pixel_in,
    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic [PIX_W-1:0] pixel_out,
    output      logic             frame_last,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int EH  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = $clog2(MAX_WIDTH + 2);
    localparam int XWW = (EW > CFG_W) ? EW : CFG_W;
    localparam int XWH = (EH > CFG_W) ? EH : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0]  width_reg, height_reg;
    logic [MASK_W-1:0] care_reg, value_reg;
    logic              restart;

    // Stream position
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [PW-1:0] pend_reg, pend_next;

    // Effective frame size
    logic [XWW-1:0] wide_w;
    logic [XWH-1:0] wide_h;
    logic [EW-1:0]  eff_w;
    logic [EH-1:0]  eff_h;

    // Address stage
    logic          accept;
    logic          is_pixel;
    logic          pend_full;
    logic          emit0;
    logic [CW-1:0] addr0;
    s1_t           s1_in;

    // Data stage
    logic             s1_valid_reg;
    s1_t              s1_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] fwd_data_reg;
    logic [PIX_W-1:0] up_rdata, mid_rdata, top;
    win_t             win_reg, win_next;
    result_t          res;
    logic             push;

    // Queue
    result_t    head;
    logic [1:0] level;
    logic [2:0] committed;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1024);
            height_reg <= CFG_W'(1024);
            care_reg   <= MASK_W'(23);
            value_reg  <= MASK_W'(7);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_CARE:   care_reg   <= cfg_data[MASK_W-1:0];
                REG_VALUE:  value_reg  <= cfg_data[MASK_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp size to 1..MAX
    always_comb
    begin
        wide_w = XWW'(width_reg);
        wide_h = XWH'(height_reg);
        if (wide_w == '0)
        begin
            eff_w = EW'(1);
        end
        else if (wide_w > XWW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(wide_w);
        end
        if (wide_h == '0)
        begin
            eff_h = EH'(1);
        end
        else if (wide_h > XWH'(MAX_HEIGHT))
        begin
            eff_h = EH'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = EH'(wide_h);
        end
    end

    // accept and queue space
    assign committed = {1'b0, level} + {2'b00, s1_valid_reg && s1_reg.emit};
    assign in_stall  = (committed >= 3'd3);
    assign accept    = in_valid && !in_stall;
    assign is_pixel  = (opcode == OP_PIXEL);

    // address stage: decide emission and advance positions
    always_comb
    begin
        pend_full = (pend_reg >= PW'(eff_w) + PW'(1));
        emit0     = is_pixel ? pend_full : (pend_reg != '0);
        addr0     = is_pixel ? in_col_reg : out_col_reg;

        s1_in.is_pixel  = is_pixel;
        s1_in.emit      = emit0;
        s1_in.border    = (out_row_reg == '0) || (out_col_reg == '0)
                          || (EH'(out_row_reg) == eff_h - EH'(1))
                          || (EW'(out_col_reg) == eff_w - EW'(1));
        s1_in.last      = (EH'(out_row_reg) == eff_h - EH'(1))
                          && (EW'(out_col_reg) == eff_w - EW'(1));
        s1_in.use_upper = pend_full;
        s1_in.fwd       = s1_valid_reg && s1_reg.is_pixel && (s1_addr_reg == addr0);
        s1_in.px        = pixel_in;

        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (accept)
        begin
            if (is_pixel)
            begin
                in_col_next = (EW'(in_col_reg) + EW'(1) >= eff_w) ? '0 : in_col_reg + CW'(1);
                if (!pend_full)
                begin
                    pend_next = pend_reg + PW'(1);
                end
            end
            else if (pend_reg != '0)
            begin
                pend_next = pend_reg - PW'(1);
            end
            if (emit0)
            begin
                if (EW'(out_col_reg) + EW'(1) >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = (EH'(out_row_reg) + EH'(1) >= eff_h) ? '0
                                   : out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            in_col_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg   <= in_col_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= accept;
        end
    end

    // stage payload; forward data is the middle read written back to upper last cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg      <= s1_in;
            s1_addr_reg <= addr0;
        end
        fwd_data_reg <= mid_rdata;
    end

    // line stores: middle written at read time, upper written in the following cycle
    hmt_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (PIX_W)
    ) u_mid_ram (
        .clk     (clk),
        .wr_en   (accept && is_pixel),
        .wr_addr (addr0),
        .wr_data (pixel_in),
        .rd_en   (accept),
        .rd_addr (addr0),
        .rd_data (mid_rdata)
    );

    hmt_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (PIX_W)
    ) u_up_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg && s1_reg.is_pixel),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_rdata),
        .rd_en   (accept),
        .rd_addr (addr0),
        .rd_data (up_rdata)
    );

    // data stage: window shift and result
    always_comb
    begin
        top         = s1_reg.fwd ? fwd_data_reg : up_rdata;
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_rdata;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_reg.px;

        res.frame_last = s1_reg.last;
        if (!s1_reg.is_pixel)
        begin
            res.pixel_out = s1_reg.use_upper ? top : mid_rdata;
        end
        else if (s1_reg.border)
        begin
            res.pixel_out = win_next[4];
        end
        else
        begin
            res.pixel_out = win_match(win_next, care_reg, value_reg) ? PIX_MAX : PIX_MIN;
        end
        push = s1_valid_reg && s1_reg.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (restart)
        begin
            win_reg <= '0;
        end
        else if (s1_valid_reg && s1_reg.is_pixel)
        begin
            win_reg <= win_next;
        end
    end

    hmt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .pop       (!out_stall),
        .valid     (out_valid),
        .head      (head),
        .level     (level)
    );

    assign pixel_out  = head.pixel_out;
    assign frame_last = head.frame_last;

    // backlog never exceeds one row plus one pixel
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        PW'(eff_w) + PW'(1) >= pend_reg)
        else $error("pending count above row length plus one");

    // positions stay inside the row
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (EW'(in_col_reg) < eff_w) && (EW'(out_col_reg) < eff_w))
        else $error("column counter outside the image");

    // a result leaving the data stage reaches the output
    a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid)
        else $error("emitted result not presented");

    // queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (level == 2'd3) && out_stall))
        else $error("result queue overflow");

endmodule

`default_nettype wire
